// ===== rtl/core/ppls_pkg.sv =====
// ---------------------------------------------------------------------------
// ppls_pkg
// Shared widths, types, register codes and helpers of the point light shader.
// ---------------------------------------------------------------------------
`default_nettype none

package ppls_pkg;

  // Coordinates and differences
  localparam int POS_W   = 16;
  localparam int DIFF_W  = POS_W + 1;
  localparam int MAG_W   = DIFF_W - 1;

  // Unit vectors, Q1.14
  localparam int FRAC_W  = 14;
  localparam int UNIT    = 1 << FRAC_W;
  localparam int UNIT_W  = FRAC_W + 2;
  localparam int MAGU_W  = FRAC_W + 1;
  localparam int DOT_W   = 2 * UNIT_W;

  // Colors and shade, Q1.10 and Q2.10
  localparam int COL_W     = 11;
  localparam int COL_FRAC  = COL_W - 1;
  localparam int COL_MAX   = 1 << COL_FRAC;
  localparam int SHADE_W   = 12;
  localparam int SHADE_MAX = (1 << SHADE_W) - 1;
  localparam int AMB_K     = 102;
  localparam int AMB_W     = 7;
  localparam int PROD_SH   = COL_FRAC + FRAC_W;
  localparam int SHININESS = 100;

  // Normalize unit: square root then restoring division
  localparam int SUMSQ_W    = 2 * MAG_W + 2;
  localparam int RAD_SH     = 16;
  localparam int RAD_W      = SUMSQ_W + RAD_SH;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = RAD_W + 1;
  localparam int LEN_W      = SQRT_STEPS;
  localparam int DIV_SH     = 22;
  localparam int DIV_STEPS  = FRAC_W + 1;
  localparam int REM_W      = MAG_W + DIV_SH + 2;
  localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 3;

  // Back pipeline: two normalize passes, dot/reflect stages, power chain, color
  localparam int BACK_LAT = 2 * NORM_LAT + SHININESS + 9;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 3 * COL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X  = 3'd0,
    CFG_LIGHT_Y  = 3'd1,
    CFG_LIGHT_Z  = 3'd2,
    CFG_AMBIENT  = 3'd3,
    CFG_DIFFUSE  = 3'd4,
    CFG_SPECULAR = 3'd5
  } cfg_idx_t;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic [MAGU_W-1:0]        mag_t;
  typedef logic [COL_W-1:0]         color_t;

  typedef pos_t   [2:0] light_t;
  typedef diff_t  [2:0] dvec_t;
  typedef unit_t  [2:0] uvec_t;
  typedef color_t [2:0] rgb_t;

  typedef struct packed {
    dvec_t nrm;
    dvec_t ldir;
    dvec_t vdir;
    rgb_t  col;
  } work_t;

  typedef struct packed {
    rgb_t amb;
    rgb_t dif;
    rgb_t spc;
  } intens_t;

  function automatic color_t sat_color(input logic [COL_W-1:0] c);
    return (c > COL_W'(COL_MAX)) ? COL_W'(COL_MAX) : c;
  endfunction

  function automatic rgb_t sat_rgb(input logic [CFG_W-1:0] v);
    rgb_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = sat_color(v[COL_W*i +: COL_W]);
    end
    return r;
  endfunction

  // max(t,0) >> 14, saturated to one
  function automatic mag_t clamp_dot(input logic signed [DOT_W+1:0] t);
    logic signed [DOT_W+1:0] sh;
    sh = t >>> FRAC_W;
    if (t <= 0) begin
      return '0;
    end else if (sh > (DOT_W+2)'(UNIT)) begin
      return MAGU_W'(UNIT);
    end
    return sh[MAGU_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppls_front.sv =====
// ---------------------------------------------------------------------------
// ppls_front
// Accept a fragment, form light and view differences, saturate the color.
// ---------------------------------------------------------------------------
`default_nettype none

module ppls_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  ppls_pkg::pos_t    point_x,
  input  ppls_pkg::pos_t    point_y,
  input  ppls_pkg::pos_t    point_z,
  input  ppls_pkg::pos_t    normal_x,
  input  ppls_pkg::pos_t    normal_y,
  input  ppls_pkg::pos_t    normal_z,
  input  ppls_pkg::color_t  base_red,
  input  ppls_pkg::color_t  base_green,
  input  ppls_pkg::color_t  base_blue,
  input  ppls_pkg::pos_t    eye_x,
  input  ppls_pkg::pos_t    eye_y,
  input  ppls_pkg::pos_t    eye_z,
  input  ppls_pkg::light_t  light,
  input  logic              full,
  output logic              push,
  output ppls_pkg::work_t   work
);

  ppls_pkg::light_t pt;
  ppls_pkg::light_t nr;
  ppls_pkg::light_t ey;

  assign pt = {point_z, point_y, point_x};
  assign nr = {normal_z, normal_y, normal_x};
  assign ey = {eye_z, eye_y, eye_x};

  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      work.nrm[i]  = {nr[i][ppls_pkg::POS_W-1], nr[i]};
      work.ldir[i] = {light[i][ppls_pkg::POS_W-1], light[i]}
                   - {pt[i][ppls_pkg::POS_W-1], pt[i]};
      work.vdir[i] = {ey[i][ppls_pkg::POS_W-1], ey[i]}
                   - {pt[i][ppls_pkg::POS_W-1], pt[i]};
    end
    work.col[0] = ppls_pkg::sat_color(base_red);
    work.col[1] = ppls_pkg::sat_color(base_green);
    work.col[2] = ppls_pkg::sat_color(base_blue);
  end

endmodule

`default_nettype wire

// ===== rtl/core/ppls_fifo.sv =====
// ---------------------------------------------------------------------------
// ppls_fifo
// Short queue of classified fragments between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module ppls_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            pop,
  input  ppls_pkg::work_t wdata,
  output ppls_pkg::work_t rdata,
  output logic            full,
  output logic            empty
);

  ppls_pkg::work_t mem [ppls_pkg::FIFO_DEPTH];
  logic [ppls_pkg::FIFO_AW-1:0] wr_ptr;
  logic [ppls_pkg::FIFO_AW-1:0] rd_ptr;
  logic [ppls_pkg::FIFO_AW:0]   count;

  assign full  = (count == (ppls_pkg::FIFO_AW+1)'(ppls_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ppls_norm.sv =====
// ---------------------------------------------------------------------------
// ppls_norm
// Pipelined vector normalize: sum of squares, bit-serial square root, restoring
// division per component, sign restore. One vector per cycle while en is high.
// ---------------------------------------------------------------------------
`default_nettype none

module ppls_norm (
  input  logic            clk,
  input  logic            en,
  input  ppls_pkg::dvec_t d,
  output ppls_pkg::uvec_t u
);

  localparam int SQ = ppls_pkg::SQRT_STEPS;
  localparam int DV = ppls_pkg::DIV_STEPS;
  localparam int RW = ppls_pkg::ROOT_W;
  localparam int MW = ppls_pkg::MAG_W;
  localparam int EW = ppls_pkg::REM_W;

  logic [MW-1:0]   mag [3];
  logic [MW-1:0]   m1 [3];
  logic [2*MW-1:0] sq1 [3];
  logic [2:0]      n1;

  logic [RW-1:0] sv [0:SQ];
  logic [RW-1:0] sr [0:SQ];
  logic [MW-1:0] sm [0:SQ][3];
  logic [2:0]    sn [0:SQ];
  logic [RW-1:0] sb [1:SQ];
  logic [RW-1:0] st [1:SQ];
  logic          sge [1:SQ];

  logic [EW-1:0]                 dr [1:DV][3];
  logic [ppls_pkg::MAGU_W-1:0]   dq [1:DV][3];
  logic [ppls_pkg::LEN_W-1:0]    dl [1:DV];
  logic [2:0]                    dn [1:DV];
  logic [EW-1:0]                 rin [1:DV][3];
  logic [ppls_pkg::MAGU_W-1:0]   qin [1:DV][3];
  logic [ppls_pkg::LEN_W-1:0]    lin [1:DV];
  logic [2:0]                    nin [1:DV];
  logic [EW-1:0]                 dsh [1:DV];
  logic                          dge [1:DV][3];

  ppls_pkg::mag_t qf [3];
  logic [ppls_pkg::SUMSQ_W-1:0] ssum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i][ppls_pkg::DIFF_W-1] ? MW'(-d[i]) : d[i][MW-1:0];
    end
    ssum = ppls_pkg::SUMSQ_W'(sq1[0]) + ppls_pkg::SUMSQ_W'(sq1[1])
         + ppls_pkg::SUMSQ_W'(sq1[2]);
    for (int k = 1; k <= SQ; k++) begin
      sb[k]  = RW'(1) << (2 * (SQ - k));
      st[k]  = sr[k-1] + sb[k];
      sge[k] = (sv[k-1] >= st[k]);
    end
    for (int i = 0; i < 3; i++) begin
      rin[1][i] = EW'(sm[SQ][i]) << ppls_pkg::DIV_SH;
      qin[1][i] = '0;
    end
    lin[1] = sr[SQ][ppls_pkg::LEN_W-1:0];
    nin[1] = sn[SQ];
    for (int k = 2; k <= DV; k++) begin
      rin[k] = dr[k-1];
      qin[k] = dq[k-1];
      lin[k] = dl[k-1];
      nin[k] = dn[k-1];
    end
    for (int k = 1; k <= DV; k++) begin
      dsh[k] = EW'(lin[k]) << (DV - k);
      for (int i = 0; i < 3; i++) begin
        dge[k][i] = (lin[k] != '0) && (rin[k][i] >= dsh[k]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      qf[i] = (dq[DV][i] > ppls_pkg::MAGU_W'(ppls_pkg::UNIT)) ?
              ppls_pkg::MAGU_W'(ppls_pkg::UNIT) : dq[DV][i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and squares
      for (int i = 0; i < 3; i++) begin
        m1[i]  <= mag[i];
        sq1[i] <= mag[i] * mag[i];
        n1[i]  <= d[i][ppls_pkg::DIFF_W-1];
      end
      // radicand
      sv[0] <= RW'(ssum) << ppls_pkg::RAD_SH;
      sr[0] <= '0;
      sm[0] <= m1;
      sn[0] <= n1;
      // one root bit per stage
      for (int k = 1; k <= SQ; k++) begin
        if (sge[k]) begin
          sv[k] <= sv[k-1] - st[k];
          sr[k] <= (sr[k-1] >> 1) + sb[k];
        end else begin
          sv[k] <= sv[k-1];
          sr[k] <= sr[k-1] >> 1;
        end
        sm[k] <= sm[k-1];
        sn[k] <= sn[k-1];
      end
      // one quotient bit per stage
      for (int k = 1; k <= DV; k++) begin
        for (int i = 0; i < 3; i++) begin
          if (dge[k][i]) begin
            dr[k][i] <= rin[k][i] - dsh[k];
            dq[k][i] <= qin[k][i] | (ppls_pkg::MAGU_W'(1) << (DV - k));
          end else begin
            dr[k][i] <= rin[k][i];
            dq[k][i] <= qin[k][i];
          end
        end
        dl[k] <= lin[k];
        dn[k] <= nin[k];
      end
      // restore sign
      for (int i = 0; i < 3; i++) begin
        u[i] <= dn[DV][i] ? ppls_pkg::UNIT_W'(0) - ppls_pkg::UNIT_W'(qf[i])
                          : ppls_pkg::UNIT_W'(qf[i]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ppls_back.sv =====
// ---------------------------------------------------------------------------
// ppls_back
// Shading pipeline: normalize N, L, V; N.L; reflect; normalize R; V.R;
// power chain; color products and sum. Advances as one whole.
// ---------------------------------------------------------------------------
`default_nettype none

module ppls_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  ppls_pkg::work_t               work,
  output logic                          pop,
  input  ppls_pkg::intens_t             intens,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppls_pkg::SHADE_W-1:0]  shade_red,
  output logic [ppls_pkg::SHADE_W-1:0]  shade_green,
  output logic [ppls_pkg::SHADE_W-1:0]  shade_blue
);

  localparam int NL  = ppls_pkg::NORM_LAT;
  localparam int SH  = ppls_pkg::SHININESS;
  localparam int BL  = ppls_pkg::BACK_LAT;
  localparam int DW  = ppls_pkg::DOT_W;
  localparam int MU  = ppls_pkg::MAGU_W;
  localparam int RSH = ppls_pkg::FRAC_W - 1;
  localparam int CPW = 2 * ppls_pkg::COL_W;
  localparam int FPW = CPW + MU;
  localparam int SW  = ppls_pkg::SHADE_W;

  logic adv;
  logic vld [BL];

  ppls_pkg::uvec_t un, ul, uv, ur;
  ppls_pkg::rgb_t  col1 [NL];

  ppls_pkg::uvec_t b1_n, b1_l, b1_v;
  ppls_pkg::rgb_t  b1_col;
  logic signed [DW-1:0] b1_prod [3];

  ppls_pkg::uvec_t b2_n, b2_l, b2_v;
  ppls_pkg::rgb_t  b2_col;
  ppls_pkg::mag_t  b2_ndl;

  logic signed [DW-1:0] b3_pr [3];
  ppls_pkg::uvec_t b3_l, b3_v;
  ppls_pkg::rgb_t  b3_col;
  ppls_pkg::mag_t  b3_ndl;

  ppls_pkg::dvec_t b4_rd;
  ppls_pkg::uvec_t b4_v;
  ppls_pkg::rgb_t  b4_col;
  ppls_pkg::mag_t  b4_ndl;

  ppls_pkg::uvec_t v2 [NL];
  ppls_pkg::mag_t  ndl2 [NL];
  ppls_pkg::rgb_t  col2 [NL];

  logic signed [DW-1:0] c1_prod [3];
  ppls_pkg::mag_t  c1_ndl;
  ppls_pkg::rgb_t  c1_col;

  ppls_pkg::mag_t  pw [0:SH];
  ppls_pkg::mag_t  pvr [0:SH];
  ppls_pkg::mag_t  pndl [0:SH];
  ppls_pkg::rgb_t  pcol [0:SH];
  logic [2*MU-1:0] pprod [1:SH];

  logic [CPW-1:0] d1_a [3];
  logic [CPW-1:0] d1_b [3];
  ppls_pkg::mag_t d1_ndl, d1_p;

  logic [SW-1:0] d2_dif [3];
  logic [SW-1:0] d2_spc [3];

  logic signed [DW+1:0] nl_sum, vr_sum;
  logic signed [DW-1:0] qt [3];
  logic signed [DW-1:0] rdw [3];
  logic [FPW-1:0]       fdif [3];
  logic [FPW-1:0]       fspc [3];
  logic [ppls_pkg::COL_W+ppls_pkg::AMB_W-1:0] famb [3];
  logic [SW:0]          tot [3];
  logic [SW-1:0]        shade [3];

  // hold every stage while the result waits
  assign adv       = !vld[BL-1] || out_ready;
  assign pop       = adv && !empty;
  assign out_valid = vld[BL-1];
  assign shade_red   = shade[0];
  assign shade_green = shade[1];
  assign shade_blue  = shade[2];

  ppls_norm u_norm_n (.clk(clk), .en(adv), .d(work.nrm),  .u(un));
  ppls_norm u_norm_l (.clk(clk), .en(adv), .d(work.ldir), .u(ul));
  ppls_norm u_norm_v (.clk(clk), .en(adv), .d(work.vdir), .u(uv));
  ppls_norm u_norm_r (.clk(clk), .en(adv), .d(b4_rd),     .u(ur));

  always_comb begin
    nl_sum = $signed(b1_prod[0]) + $signed(b1_prod[1]) + $signed(b1_prod[2]);
    vr_sum = $signed(c1_prod[0]) + $signed(c1_prod[1]) + $signed(c1_prod[2]);
    for (int i = 0; i < 3; i++) begin
      // truncate toward zero
      qt[i]  = (b3_pr[i] >= 0) ? (b3_pr[i] >>> RSH)
                               : ((b3_pr[i] + DW'((1 << RSH) - 1)) >>> RSH);
      rdw[i] = qt[i] - DW'($signed(b3_l[i]));
      fdif[i] = FPW'(d1_a[i]) * FPW'(d1_ndl);
      fspc[i] = FPW'(d1_b[i]) * FPW'(d1_p);
      famb[i] = (ppls_pkg::COL_W+ppls_pkg::AMB_W)'(intens.amb[i])
              * (ppls_pkg::COL_W+ppls_pkg::AMB_W)'(ppls_pkg::AMB_K);
      tot[i]  = (SW+1)'(famb[i][ppls_pkg::COL_FRAC +: ppls_pkg::AMB_W + 1])
              + (SW+1)'(d2_dif[i]) + (SW+1)'(d2_spc[i]);
    end
    for (int k = 1; k <= SH; k++) begin
      pprod[k] = (2*MU)'(pw[k-1]) * (2*MU)'(pvr[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BL; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= pop;
      for (int k = 1; k < BL; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // color rides alongside the first normalize pass
      col1[0] <= work.col;
      for (int k = 1; k < NL; k++) begin
        col1[k] <= col1[k-1];
      end
      // N.L products
      b1_n <= un;
      b1_l <= ul;
      b1_v <= uv;
      b1_col <= col1[NL-1];
      for (int i = 0; i < 3; i++) begin
        b1_prod[i] <= $signed(un[i]) * $signed(ul[i]);
      end
      b2_n <= b1_n;
      b2_l <= b1_l;
      b2_v <= b1_v;
      b2_col <= b1_col;
      b2_ndl <= ppls_pkg::clamp_dot(nl_sum);
      // reflection
      for (int i = 0; i < 3; i++) begin
        b3_pr[i] <= $signed({1'b0, b2_ndl}) * $signed(b2_n[i]);
      end
      b3_l <= b2_l;
      b3_v <= b2_v;
      b3_col <= b2_col;
      b3_ndl <= b2_ndl;
      for (int i = 0; i < 3; i++) begin
        b4_rd[i] <= rdw[i][ppls_pkg::DIFF_W-1:0];
      end
      b4_v <= b3_v;
      b4_col <= b3_col;
      b4_ndl <= b3_ndl;
      // side data across the second normalize pass
      v2[0]   <= b4_v;
      ndl2[0] <= b4_ndl;
      col2[0] <= b4_col;
      for (int k = 1; k < NL; k++) begin
        v2[k]   <= v2[k-1];
        ndl2[k] <= ndl2[k-1];
        col2[k] <= col2[k-1];
      end
      // V.R
      for (int i = 0; i < 3; i++) begin
        c1_prod[i] <= $signed(v2[NL-1][i]) * $signed(ur[i]);
      end
      c1_ndl <= ndl2[NL-1];
      c1_col <= col2[NL-1];
      pw[0]   <= MU'(ppls_pkg::UNIT);
      pvr[0]  <= ppls_pkg::clamp_dot(vr_sum);
      pndl[0] <= c1_ndl;
      pcol[0] <= c1_col;
      // power chain, one multiply per stage
      for (int k = 1; k <= SH; k++) begin
        pw[k]   <= pprod[k][ppls_pkg::FRAC_W +: MU];
        pvr[k]  <= pvr[k-1];
        pndl[k] <= pndl[k-1];
        pcol[k] <= pcol[k-1];
      end
      // intensity times color
      for (int i = 0; i < 3; i++) begin
        d1_a[i] <= CPW'(intens.dif[i]) * CPW'(pcol[SH][i]);
        d1_b[i] <= CPW'(intens.spc[i]) * CPW'(pcol[SH][i]);
      end
      d1_ndl <= pndl[SH];
      d1_p   <= pw[SH];
      for (int i = 0; i < 3; i++) begin
        d2_dif[i] <= fdif[i][ppls_pkg::PROD_SH +: SW];
        d2_spc[i] <= fspc[i][ppls_pkg::PROD_SH +: SW];
      end
      // sum and result register
      for (int i = 0; i < 3; i++) begin
        shade[i] <= (tot[i] > (SW+1)'(ppls_pkg::SHADE_MAX)) ?
                    SW'(ppls_pkg::SHADE_MAX) : tot[i][SW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/phong_point_light_shader.sv =====
// ---------------------------------------------------------------------------
// phong_point_light_shader
// Phong shading of one fragment against one point light, fully pipelined.
// ---------------------------------------------------------------------------
// Takes one fragment per cycle and returns one RGB result per cycle while
// the output is not stalled. A fragment is classified in the front (light
// and view differences formed, color saturated to one) and parked in a
// four-entry queue; the back pipeline pulls from the queue. Its depth
// comes from the normalize units (25-stage square root and 15-stage
// divider, two passes) and the 100-stage multiply chain for the specular
// power. An output stall holds the whole back pipeline; the queue keeps
// accepting until it fills. Configuration (light position and the three
// intensity triples) is written on its own port, always ready; intensity
// channels saturate to one on write. Write it only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module phong_point_light_shader (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ppls_pkg::pos_t                        point_x,
  input  ppls_pkg::pos_t                        point_y,
  input  ppls_pkg::pos_t                        point_z,
  input  ppls_pkg::pos_t                        normal_x,
  input  ppls_pkg::pos_t                        normal_y,
  input  ppls_pkg::pos_t                        normal_z,
  input  ppls_pkg::color_t                      base_red,
  input  ppls_pkg::color_t                      base_green,
  input  ppls_pkg::color_t                      base_blue,
  input  ppls_pkg::pos_t                        eye_x,
  input  ppls_pkg::pos_t                        eye_y,
  input  ppls_pkg::pos_t                        eye_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ppls_pkg::SHADE_W-1:0]          shade_red,
  output logic [ppls_pkg::SHADE_W-1:0]          shade_green,
  output logic [ppls_pkg::SHADE_W-1:0]          shade_blue,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppls_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppls_pkg::CFG_W-1:0]            cfg_data
);

  ppls_pkg::light_t  light;
  ppls_pkg::intens_t intens;
  ppls_pkg::work_t   fr_work;
  ppls_pkg::work_t   q_work;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light <= '0;
      for (int i = 0; i < 3; i++) begin
        intens.amb[i] <= ppls_pkg::COL_W'(ppls_pkg::AMB_K);
        intens.dif[i] <= ppls_pkg::COL_W'(ppls_pkg::COL_MAX);
        intens.spc[i] <= ppls_pkg::COL_W'(ppls_pkg::COL_MAX);
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        ppls_pkg::CFG_LIGHT_X:  light[0]   <= cfg_data[ppls_pkg::POS_W-1:0];
        ppls_pkg::CFG_LIGHT_Y:  light[1]   <= cfg_data[ppls_pkg::POS_W-1:0];
        ppls_pkg::CFG_LIGHT_Z:  light[2]   <= cfg_data[ppls_pkg::POS_W-1:0];
        ppls_pkg::CFG_AMBIENT:  intens.amb <= ppls_pkg::sat_rgb(cfg_data);
        ppls_pkg::CFG_DIFFUSE:  intens.dif <= ppls_pkg::sat_rgb(cfg_data);
        ppls_pkg::CFG_SPECULAR: intens.spc <= ppls_pkg::sat_rgb(cfg_data);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // classify incoming fragments
  ppls_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .base_red   (base_red),
    .base_green (base_green),
    .base_blue  (base_blue),
    .eye_x      (eye_x),
    .eye_y      (eye_y),
    .eye_z      (eye_z),
    .light      (light),
    .full       (full),
    .push       (push),
    .work       (fr_work)
  );

  // decouple front from the back pipeline stall
  ppls_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .wdata (fr_work),
    .rdata (q_work),
    .full  (full),
    .empty (empty)
  );

  // shading pipeline
  ppls_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .work        (q_work),
    .pop         (pop),
    .intens      (intens),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shade_red   (shade_red),
    .shade_green (shade_green),
    .shade_blue  (shade_blue)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ppls_checker.sv =====
// ---------------------------------------------------------------------------
// ppls_checker
// Port-level checks of the shader, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module ppls_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ppls_pkg::SHADE_W-1:0]  shade_red,
  input logic [ppls_pkg::SHADE_W-1:0]  shade_green,
  input logic [ppls_pkg::SHADE_W-1:0]  shade_blue
);

  localparam int PEAK = ((ppls_pkg::COL_MAX * ppls_pkg::AMB_K) >> ppls_pkg::COL_FRAC)
                      + 2 * ppls_pkg::COL_MAX;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shade_red)
      && $stable(shade_green) && $stable(shade_blue))
    else $error("stalled result changed");

  // reset empties the pipeline and the queue
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not clear after reset");

  // a result never exceeds ambient plus full diffuse and specular
  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shade_red <= ppls_pkg::SHADE_W'(PEAK)
      && shade_green <= ppls_pkg::SHADE_W'(PEAK)
      && shade_blue <= ppls_pkg::SHADE_W'(PEAK))
    else $error("shade above peak");

  // no result can leave within the first cycles after reset
  a_no_early: assert property (@(posedge clk)
    $past(rst) && !rst |=> !out_valid)
    else $error("result too soon after reset");

endmodule

bind phong_point_light_shader ppls_checker u_checker (.*);

`default_nettype wire

// ===== verif/phong_point_light_shader_chk.sv =====
// ---------------------------------------------------------------------------
// phong_point_light_shader_chk
// Shading predictor and result checker for the point light shader.
// ---------------------------------------------------------------------------
// Watches the configuration, fragment and shade channels. Each accepted
// fragment is shaded by an integer model of the block at its widths and the
// expected RGB is queued; each accepted shade result is compared with the
// oldest entry of that queue.
// ---------------------------------------------------------------------------
module phong_point_light_shader_chk
  import ppls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  pos_t                 point_x,
  input  pos_t                 point_y,
  input  pos_t                 point_z,
  input  pos_t                 normal_x,
  input  pos_t                 normal_y,
  input  pos_t                 normal_z,
  input  color_t               base_red,
  input  color_t               base_green,
  input  color_t               base_blue,
  input  pos_t                 eye_x,
  input  pos_t                 eye_y,
  input  pos_t                 eye_z,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [SHADE_W-1:0]   shade_red,
  input  logic [SHADE_W-1:0]   shade_green,
  input  logic [SHADE_W-1:0]   shade_blue,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3*SHADE_W-1:0] shade_rgb_t;
  typedef longint vec3_t [3];

  longint     lpos [3];
  longint     amb_i [3], dif_i [3], spc_i [3];
  shade_rgb_t shade_q [$];

  assign pending = shade_q.size();

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Q8.8 (or Q1.14) difference to Q1.14 unit vector; zero stays zero
  function automatic vec3_t to_unit(vec3_t d);
    vec3_t  u;
    longint s, len, m, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += d[i] * d[i];
    len = int_sqrt(longint'(s) << 16);
    for (int i = 0; i < 3; i++) begin
      m = d[i] < 0 ? -d[i] : d[i];
      q = (len != 0) ? (m << 22) / len : 0;
      if (q > UNIT) q = UNIT;
      u[i] = d[i] < 0 ? -q : q;
    end
    return u;
  endfunction

  function automatic longint facing(vec3_t a, vec3_t b);
    longint t;
    t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (t <= 0) return 0;
    t = t >> 14;
    return t > UNIT ? UNIT : t;
  endfunction

  function automatic shade_rgb_t shade_fragment(vec3_t p, vec3_t nr, vec3_t e,
                                                longint c [3]);
    vec3_t      ld, vd, rd, n, l, v, r;
    longint     ndl, vr, pw, sum;
    shade_rgb_t res;
    for (int i = 0; i < 3; i++) begin
      ld[i] = lpos[i] - p[i];
      vd[i] = e[i] - p[i];
    end
    n = to_unit(nr);
    l = to_unit(ld);
    v = to_unit(vd);
    ndl = facing(n, l);
    // SV division truncates toward zero, like the block
    for (int i = 0; i < 3; i++) rd[i] = (2 * ndl * n[i]) / UNIT - l[i];
    r = to_unit(rd);
    vr = facing(v, r);
    pw = UNIT;
    for (int k = 0; k < SHININESS; k++) pw = (pw * vr) >> 14;
    for (int i = 0; i < 3; i++) begin
      sum = ((amb_i[i] * AMB_K) >> 10) + ((dif_i[i] * c[i] * ndl) >> 24)
          + ((spc_i[i] * c[i] * pw) >> 24);
      if (sum > SHADE_MAX) sum = SHADE_MAX;
      res[SHADE_W*i +: SHADE_W] = sum[SHADE_W-1:0];
    end
    return res;
  endfunction

  function automatic longint clip_color(logic [COL_W-1:0] c);
    return c > COL_MAX ? COL_MAX : longint'(c);
  endfunction

  task automatic store_intens(ref longint dst [3], input logic [CFG_W-1:0] v);
    for (int i = 0; i < 3; i++) dst[i] = clip_color(v[COL_W*i +: COL_W]);
  endtask

  task automatic check_field(string name, logic [SHADE_W-1:0] exp_v,
                             logic [SHADE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    vec3_t      p, nr, e;
    longint     c [3];
    shade_rgb_t exp_rgb;
    if (rst) begin
      lpos = '{0, 0, 0};
      amb_i = '{AMB_K, AMB_K, AMB_K};
      dif_i = '{COL_MAX, COL_MAX, COL_MAX};
      spc_i = '{COL_MAX, COL_MAX, COL_MAX};
      shade_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LIGHT_X:  lpos[0] = longint'(signed'(cfg_data[POS_W-1:0]));
          CFG_LIGHT_Y:  lpos[1] = longint'(signed'(cfg_data[POS_W-1:0]));
          CFG_LIGHT_Z:  lpos[2] = longint'(signed'(cfg_data[POS_W-1:0]));
          CFG_AMBIENT:  store_intens(amb_i, cfg_data);
          CFG_DIFFUSE:  store_intens(dif_i, cfg_data);
          CFG_SPECULAR: store_intens(spc_i, cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        p  = '{point_x, point_y, point_z};
        nr = '{normal_x, normal_y, normal_z};
        e  = '{eye_x, eye_y, eye_z};
        c  = '{clip_color(base_red), clip_color(base_green), clip_color(base_blue)};
        shade_q.push_back(shade_fragment(p, nr, e, c));
      end
      if (out_valid && out_ready) begin
        if (shade_q.size() == 0) begin
          $error("shade result with no fragment outstanding");
          fail_count++;
        end else begin
          exp_rgb = shade_q.pop_front();
          check_field("shade_red", exp_rgb[0 +: SHADE_W], shade_red);
          check_field("shade_green", exp_rgb[SHADE_W +: SHADE_W], shade_green);
          check_field("shade_blue", exp_rgb[2*SHADE_W +: SHADE_W], shade_blue);
        end
      end
    end
  end
endmodule

// ===== verif/phong_point_light_shader_tb.sv =====
// ---------------------------------------------------------------------------
// phong_point_light_shader_tb
// Stimulus and verdict for the Phong point light shader.
// ---------------------------------------------------------------------------
// Drives fragments in bursts across several light and intensity settings,
// stalls the shade output on its own pattern, and leaves prediction and
// comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module phong_point_light_shader_tb;
  import ppls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG   = 20000;
  localparam int DRAIN_WAIT = BACK_LAT + 50;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pos_t                 point_x = '0, point_y = '0, point_z = '0;
  pos_t                 normal_x = '0, normal_y = '0, normal_z = '0;
  color_t               base_red = '0, base_green = '0, base_blue = '0;
  pos_t                 eye_x = '0, eye_y = '0, eye_z = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SHADE_W-1:0]   shade_red, shade_green, shade_blue;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  bit                   hold_out = 1'b0;
  bit                   stim_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  phong_point_light_shader u_dut (.*);

  phong_point_light_shader_chk u_chk (.*);

  // Watchdog: count cycles in which no handshake of any channel happens
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG && !stim_done) begin
        $display("phong_point_light_shader verification failed");
        $finish;
      end
    end
  end

  // Output stall pattern: mostly ready, random stall runs, periodic clean runs
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_out) out_ready <= 1'b0;
    else out_ready <= (r < 70) || ((idle_cycles & 512) != 0);
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every outstanding result, then let the back pipeline settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic pos_t rand_coord(int mode);
    case (mode)
      0: return pos_t'($urandom_range(0, 65535));
      1: return pos_t'($signed($urandom_range(0, 8191)) - 4096);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return '0;
          default: return pos_t'($signed($urandom_range(0, 511)) - 256);
        endcase
      end
    endcase
  endfunction

  function automatic color_t rand_color();
    if ($urandom_range(0, 9) == 0) return color_t'($urandom_range(1025, 2047));
    return color_t'($urandom_range(0, COL_MAX));
  endfunction

  // Offer one fragment and hold it until accepted
  task automatic send_frag(pos_t p [3], pos_t n [3], color_t c [3], pos_t e [3]);
    point_x <= p[0]; point_y <= p[1]; point_z <= p[2];
    normal_x <= n[0]; normal_y <= n[1]; normal_z <= n[2];
    base_red <= c[0]; base_green <= c[1]; base_blue <= c[2];
    eye_x <= e[0]; eye_y <= e[1]; eye_z <= e[2];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(int count, bit gaps);
    pos_t   p [3], n [3], e [3];
    color_t c [3];
    int     burst, mode, gap;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        p[i] = rand_coord(mode);
        n[i] = rand_coord(mode == 0 ? 0 : 1);
        e[i] = rand_coord(mode);
        c[i] = rand_color();
      end
      // Place the eye on the mirror ray now and then so the highlight fires
      if ($urandom_range(0, 3) == 0) begin
        n = '{16'sd0, 16'sd0, 16'sd256};
        p = '{pos_t'($signed($urandom_range(0, 64)) - 32), 16'sd0, 16'sd0};
        e = '{pos_t'(-p[0]), 16'sd0, 16'sd1024};
      end
      send_frag(p, n, c, e);
      if (gaps) begin
        if (burst == 0) begin
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst = $urandom_range(1, 12);
        end else begin
          burst--;
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic directed();
    pos_t   z [3], hi [3], lo [3], up [3];
    color_t full [3], over [3], none [3];
    z = '{0, 0, 0};
    hi = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
    lo = '{16'sh8000, 16'sh8000, 16'sh8000};
    up = '{16'sd0, 16'sd0, 16'sd256};
    full = '{11'd1024, 11'd1024, 11'd1024};
    over = '{11'h7ff, 11'd1025, 11'h7ff};
    none = '{11'd0, 11'd0, 11'd0};
    // zero normal, zero light vector, zero view vector
    send_frag(z, z, full, z);
    send_frag(z, up, full, z);
    // light at the point itself, eye straight above: ambient only
    send_frag(z, up, full, up);
    // colors above one saturate
    send_frag(z, up, over, up);
    send_frag(z, up, none, up);
    // coordinate extremes
    send_frag(hi, hi, full, lo);
    send_frag(lo, lo, full, hi);
    send_frag(lo, hi, over, lo);
    send_frag(hi, lo, full, hi);
    // point above the light, normal facing down toward it
    send_frag(up, '{16'sd0, 16'sd0, -16'sd256}, full, z);
    send_frag(z, '{16'sd1, -16'sd1, 16'sd1}, full, '{16'sd300, 16'sd0, 16'sd700});
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    wait_idle();

    // Light above the origin, strong ambient; index beyond the list is dropped
    write_reg(CFG_LIGHT_X, 33'h0);
    write_reg(CFG_LIGHT_Y, 33'h0);
    write_reg(CFG_LIGHT_Z, 33'h00400);
    write_reg(CFG_AMBIENT, {11'd1024, 11'd512, 11'd1});
    write_reg(cfg_idx_t'(3'd7), 33'h1_ffff_ffff);
    send_random(120, 1'b1);
    @(posedge clk);

    // Long output hold while fragments keep coming: queue fills, input stalls
    fork
      begin
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      send_random(40, 1'b0);
    join
    wait_idle();

    // Extremes: saturated intensity fields and a far corner light
    write_reg(CFG_LIGHT_X, 33'h0_7fff);
    write_reg(CFG_LIGHT_Y, 33'h1_ffff_8000);
    write_reg(CFG_LIGHT_Z, 33'h0_8000);
    write_reg(CFG_AMBIENT, 33'h1_ffff_ffff);
    write_reg(CFG_DIFFUSE, 33'h1_ffff_ffff);
    write_reg(CFG_SPECULAR, 33'h1_ffff_ffff);
    send_random(100, 1'b1);
    wait_idle();

    // Zero intensities, then random ones with the light near the scene
    write_reg(CFG_AMBIENT, 33'h0);
    write_reg(CFG_DIFFUSE, 33'h0);
    write_reg(CFG_SPECULAR, 33'h0);
    send_random(40, 1'b1);
    wait_idle();
    write_reg(CFG_LIGHT_X, 33'(pos_t'($signed($urandom_range(0, 1023)) - 512)));
    write_reg(CFG_LIGHT_Y, 33'($urandom_range(0, 65535)));
    write_reg(CFG_LIGHT_Z, 33'h0_0200);
    write_reg(CFG_AMBIENT, {1'($urandom_range(0, 1)), 32'($urandom())});
    write_reg(CFG_DIFFUSE, {1'($urandom_range(0, 1)), 32'($urandom())});
    write_reg(CFG_SPECULAR, {11'd1024, 11'd700, 11'd300});
    send_random(150, 1'b1);
    wait_idle();

    stim_done = 1'b1;
    if (fail_count == 0) begin
      $display("phong_point_light_shader verification clean");
    end else begin
      $display("phong_point_light_shader verification failed");
    end
    $finish;
  end

  // wait_idle() has no ceiling; this timeout stops a lost result hanging the run
  initial begin
    #(64'd8 * 64'd2000000);
    $display("phong_point_light_shader verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/ppls_pkg.sv
rtl/core/ppls_front.sv
rtl/core/ppls_fifo.sv
rtl/core/ppls_norm.sv
rtl/core/ppls_back.sv
rtl/core/phong_point_light_shader.sv
rtl/core/ppls_checker.sv
verif/phong_point_light_shader_chk.sv
verif/phong_point_light_shader_tb.sv
